// ===== rtl/q8bq_pkg.sv =====
package q8bq_pkg;

  localparam int unsigned BLOCK_SIZE_DEF = 256;
  localparam int unsigned SUB_BLOCK_SIZE = 16;
  localparam int unsigned SUB_IDX_W      = 4;
  localparam int unsigned QUANT_W        = 8;
  localparam int unsigned LANES_W        = SUB_BLOCK_SIZE * QUANT_W;
  localparam int unsigned SUM_W          = 13;
  localparam int unsigned DIV_STEPS      = 27;

  localparam logic [30:0] INF_MAG = 31'h7f80_0000;
  localparam logic [7:0]  EXP_MAX = 8'hff;

  // Sequencer of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_DIV2,
    ST_RD,
    ST_NRM,
    ST_MUL,
    ST_RND,
    ST_QNT,
    ST_EMIT
  } q8bq_state_t;

  // Reciprocal unit sequencer
  typedef enum logic [1:0] {
    RS_IDLE,
    RS_RUN,
    RS_FIN
  } rcp_state_t;

  // Kind of the block reciprocal
  typedef enum logic [1:0] {
    RK_ZERO,
    RK_FIN,
    RK_INF
  } rk_t;

  // Kind of one product
  typedef enum logic [1:0] {
    XC_ZERO,
    XC_FIN,
    XC_SAT
  } xc_t;

  // Stage enables of the quantize datapath
  typedef struct packed {
    logic nrm_en;
    logic mul_en;
    logic rnd_en;
  } qctl_t;

endpackage

// ===== rtl/q8_block_quantizer.sv =====
// Streaming 8-bit block quantizer. Samples (raw single-precision bits) are taken one per
// cycle while busy is low, one beat per start pulse. After the last sample of a super-block
// busy rises and stays high until the final result has gone out: up to two reciprocal
// divisions (one quotient bit per cycle), then each buffered sample passes in turn through
// the shared normalize/multiply/round datapath, and each sub-block presents its result after
// its last sample. Each result is shown for exactly one cycle with out_strobe high. The
// receiver cannot stall the block, so it must take every beat in the cycle in which
// out_strobe is high.
module q8_block_quantizer #(
  parameter int unsigned BLOCK_SIZE = q8bq_pkg::BLOCK_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [31:0]                         in_sample,
  output logic                                out_strobe,
  output logic [63:0]                         out_quants_low,
  output logic [63:0]                         out_quants_high,
  output logic signed [q8bq_pkg::SUM_W-1:0]   out_sub_block_sum,
  output logic [31:0]                         out_block_scale,
  output logic [q8bq_pkg::SUB_IDX_W-1:0]      out_sub_block_index,
  output logic                                out_last_of_block
);
  import q8bq_pkg::*;

  localparam int unsigned NSUB = BLOCK_SIZE / SUB_BLOCK_SIZE;
  localparam int unsigned AW   = $clog2(BLOCK_SIZE);
  localparam int unsigned SBW  = (NSUB > 1) ? $clog2(NSUB) : 1;

  q8bq_state_t state_r, state_nxt;
  logic [AW-1:0]  fill_r;
  logic [30:0]    mag_r;
  logic [31:0]    val_r;
  logic [31:0]    mem [BLOCK_SIZE];
  logic [31:0]    rdata_r;
  logic [31:0]    recip_r, scale_r;
  rk_t            rk_r;
  logic [SBW-1:0] sb_r;
  logic [3:0]     k_r;
  logic [LANES_W-1:0] lanes_r;
  logic signed [SUM_W-1:0] sum_r;

  logic        acc, last_in, sb_last;
  logic [30:0] in_mag;
  logic        prep_zero, prep_inf, prep_den;
  logic        div_go, div_done;
  logic [23:0] div_dsr;
  logic signed [9:0] div_k;
  logic        div_sgn;
  logic [31:0] div_res;
  logic        div_ovf;
  qctl_t       qctl;
  logic signed [7:0] qv;
  logic [AW-1:0] rd_addr;

  assign acc       = start && !busy;
  assign last_in   = (fill_r == AW'(BLOCK_SIZE - 1));
  assign sb_last   = (sb_r == SBW'(NSUB - 1));
  assign in_mag    = in_sample[30:0];
  assign prep_zero = (mag_r == 31'd0);
  assign prep_inf  = (mag_r == INF_MAG);
  assign prep_den  = (mag_r[30:23] == 8'd0);
  assign div_ovf   = (div_res[30:0] == INF_MAG);
  assign rd_addr   = AW'({sb_r, k_r});

  q8bq_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .dsr   (div_dsr),
    .kexp  (div_k),
    .sgn   (div_sgn),
    .done  (div_done),
    .res   (div_res)
  );

  q8bq_quant u_quant (
    .clk   (clk),
    .ctl   (qctl),
    .rk    (rk_r),
    .recip (recip_r),
    .x     (rdata_r),
    .q     (qv)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc && last_in) state_nxt = ST_PREP;
      ST_PREP: state_nxt = (prep_zero || prep_inf || prep_den) ? ST_RD : ST_DIV1;
      ST_DIV1: if (div_done) state_nxt = div_ovf ? ST_RD : ST_DIV2;
      ST_DIV2: if (div_done) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_NRM;
      ST_NRM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_QNT;
      ST_QNT:  state_nxt = (k_r == 4'd15) ? ST_EMIT : ST_RD;
      ST_EMIT: state_nxt = sb_last ? ST_IDLE : ST_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_go     = 1'b0;
    div_dsr    = {1'b1, val_r[22:0]};
    div_k      = 10'sd134 - $signed({2'b00, val_r[30:23]});
    div_sgn    = ~val_r[31];
    qctl       = '0;
    out_strobe = 1'b0;
    busy       = 1'b1;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_PREP: div_go = !(prep_zero || prep_inf || prep_den);
      ST_DIV1: begin
        div_go  = div_done && !div_ovf;
        div_dsr = {1'b1, div_res[22:0]};
        div_k   = 10'sd127 - $signed({2'b00, div_res[30:23]});
        div_sgn = div_res[31];
      end
      ST_NRM:  qctl.nrm_en = 1'b1;
      ST_MUL:  qctl.mul_en = 1'b1;
      ST_RND:  qctl.rnd_en = 1'b1;
      ST_EMIT: out_strobe = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      mag_r   <= '0;
      val_r   <= '0;
      rk_r    <= RK_ZERO;
      sb_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      // Take a sample and track the largest magnitude, first of equals wins
      if (acc) begin
        fill_r <= last_in ? '0 : fill_r + AW'(1);
        if (in_mag <= INF_MAG && in_mag > mag_r) begin
          mag_r <= in_mag;
          val_r <= in_sample;
        end
      end
      case (state_r)
        ST_PREP: begin
          sb_r <= '0;
          k_r  <= '0;
          rk_r <= prep_den ? RK_INF : RK_ZERO;
        end
        ST_DIV1: if (div_done) rk_r <= div_ovf ? RK_INF : RK_FIN;
        ST_QNT:  k_r <= k_r + 4'd1;
        ST_EMIT: begin
          sb_r <= sb_r + SBW'(1);
          if (sb_last) begin
            mag_r <= '0;
            val_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample buffer
  always_ff @(posedge clk) begin
    if (acc) mem[fill_r] <= in_sample;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) rdata_r <= mem[rd_addr];
  end

  // Reciprocal, scale and result assembly
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        sum_r <= '0;
        if (prep_zero) scale_r <= '0;
        else if (prep_inf) scale_r <= {~val_r[31], EXP_MAX, 23'd0};
        else if (prep_den) begin
          recip_r <= {~val_r[31], EXP_MAX, 23'd0};
          scale_r <= {~val_r[31], 31'd0};
        end
      end
      ST_DIV1: if (div_done) begin
        recip_r <= div_res;
        if (div_ovf) scale_r <= {div_res[31], 31'd0};
      end
      ST_DIV2: if (div_done) scale_r <= div_res;
      ST_QNT: begin
        lanes_r <= {qv, lanes_r[LANES_W-1:QUANT_W]};
        sum_r   <= sum_r + {{(SUM_W - QUANT_W){qv[7]}}, qv};
      end
      ST_EMIT: sum_r <= '0;
      default: ;
    endcase
  end

  assign out_quants_low      = lanes_r[63:0];
  assign out_quants_high     = lanes_r[127:64];
  assign out_sub_block_sum   = sum_r;
  assign out_block_scale     = scale_r;
  assign out_sub_block_index = SUB_IDX_W'(sb_r);
  assign out_last_of_block   = sb_last;

  // Results only come out while the block is busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");

  // Sub-block results are spaced by their quantize passes
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_block) |=> !out_strobe)
    else $error("back-to-back result beats");

  // Final result of a super-block frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_of_block) |=> !busy)
    else $error("block still busy after last result");

  // Last sample of a super-block starts the computation
  a_last_in: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && fill_r == AW'(BLOCK_SIZE - 1)) |=> (busy && state_r == ST_PREP))
    else $error("super-block not closed after last sample");

endmodule

// ===== rtl/q8bq_recip.sv =====
module q8bq_recip (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [23:0]       dsr,
  input  logic signed [9:0] kexp,
  input  logic              sgn,
  output logic              done,
  output logic [31:0]       res
);
  import q8bq_pkg::*;

  rcp_state_t state_r, state_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [24:0] diff;
  logic [23:0] dsr_r;
  logic [26:0] quo_r;
  logic [4:0]  cnt_r;
  logic signed [9:0] kexp_r;
  logic        sgn_r;
  logic [31:0] res_r, res_nxt;
  logic        done_r;
  logic        qbit;
  logic        load_en, step_en, fin_en;

  logic [23:0] mant;
  logic        g, st, inc_n;
  logic signed [10:0] kx, bexp, bexp2, sh;
  logic [24:0] sum25;
  logic [4:0]  shc;
  logic [49:0] wide;
  logic [23:0] dfrac, dres;
  logic        dg, dst, inc_d;

  // One restoring step: compare, subtract, shift
  assign diff    = rem_r - {1'b0, dsr_r};
  assign qbit    = (rem_r >= {1'b0, dsr_r});
  assign rem_nxt = qbit ? {diff[23:0], 1'b0} : {rem_r[23:0], 1'b0};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RS_IDLE: if (go) state_nxt = RS_RUN;
      RS_RUN:  if (cnt_r == 5'd1) state_nxt = RS_FIN;
      RS_FIN:  state_nxt = RS_IDLE;
      default: state_nxt = RS_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load_en = 1'b0;
    step_en = 1'b0;
    fin_en  = 1'b0;
    case (state_r)
      RS_IDLE: load_en = go;
      RS_RUN:  step_en = 1'b1;
      RS_FIN:  fin_en  = 1'b1;
      default: ;
    endcase
  end

  // Normalize the quotient, then round to single with subnormal and overflow handling
  always_comb begin
    kx = $signed({kexp_r[9], kexp_r});
    if (quo_r[26]) begin
      mant = quo_r[26:3];
      g    = quo_r[2];
      st   = (|quo_r[1:0]) | (|rem_r);
      bexp = kx + 11'sd127;
    end else begin
      mant = quo_r[25:2];
      g    = quo_r[1];
      st   = quo_r[0] | (|rem_r);
      bexp = kx + 11'sd126;
    end
    inc_n = g & (st | mant[0]);
    sum25 = {1'b0, mant} + {24'd0, inc_n};
    bexp2 = bexp + (sum25[24] ? 11'sd1 : 11'sd0);

    sh    = 11'sd1 - bexp;
    shc   = (sh > 11'sd26) ? 5'd26 : sh[4:0];
    wide  = {mant, g, 25'd0} >> shc;
    dfrac = wide[49:26];
    dg    = wide[25];
    dst   = st | (|wide[24:0]);
    inc_d = dg & (dst | dfrac[0]);
    dres  = dfrac + {23'd0, inc_d};

    if (bexp >= 11'sd1) begin
      if (bexp2 >= 11'sd255) res_nxt = {sgn_r, EXP_MAX, 23'd0};
      else res_nxt = {sgn_r, bexp2[7:0], sum25[24] ? 23'd0 : sum25[22:0]};
    end else begin
      res_nxt = {sgn_r, 7'd0, dres};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= fin_en;
      if (load_en) cnt_r <= 5'(DIV_STEPS);
      else if (step_en) cnt_r <= cnt_r - 5'd1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_en) begin
      rem_r  <= 25'h080_0000;
      dsr_r  <= dsr;
      quo_r  <= '0;
      kexp_r <= kexp;
      sgn_r  <= sgn;
    end else if (step_en) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[25:0], qbit};
    end
    if (fin_en) res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/q8bq_quant.sv =====
module q8bq_quant (
  input  logic                clk,
  input  q8bq_pkg::qctl_t     ctl,
  input  q8bq_pkg::rk_t       rk,
  input  logic [31:0]         recip,
  input  logic [31:0]         x,
  output logic signed [7:0]   q
);
  import q8bq_pkg::*;

  function automatic logic [4:0] msb_pos(input logic [22:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic        sx;
  logic [7:0]  ex;
  logic [22:0] fx;
  xc_t         xc_n;
  logic [4:0]  lz;
  logic [23:0] mx_n;
  logic signed [9:0] exn_n;

  logic        sg1_r, sg2_r, sg3_r;
  xc_t         xc1_r, xc2_r, xc3_r;
  logic [23:0] mx_r;
  logic signed [9:0]  exn_r;
  logic [47:0] p_r;
  logic signed [10:0] ep0_r, ep_r;
  logic [23:0] m_r;

  logic [23:0] rm;
  logic        rg, rs, rinc;
  logic signed [10:0] rep;
  logic [24:0] rsum;

  logic [4:0]  ish;
  logic [47:0] iw;
  logic        ih, ist, iinc;
  logic [8:0]  r9;
  logic signed [7:0] qsat;

  // Classify and normalize the sample
  always_comb begin
    sx = x[31];
    ex = x[30:23];
    fx = x[22:0];
    lz = 5'd23 - msb_pos(fx);
    if (rk == RK_ZERO) xc_n = XC_ZERO;
    else if (ex == EXP_MAX && fx != 23'd0) xc_n = XC_ZERO;
    else if (ex == 8'd0 && fx == 23'd0) xc_n = XC_ZERO;
    else if (rk == RK_INF || ex == EXP_MAX) xc_n = XC_SAT;
    else xc_n = XC_FIN;
    if (ex == 8'd0) begin
      mx_n  = {1'b0, fx} << lz;
      exn_n = -10'sd126 - $signed({5'd0, lz});
    end else begin
      mx_n  = {1'b1, fx};
      exn_n = $signed({2'b00, ex}) - 10'sd127;
    end
  end

  // Round the product to single precision
  always_comb begin
    if (p_r[47]) begin
      rm  = p_r[47:24];
      rg  = p_r[23];
      rs  = |p_r[22:0];
      rep = ep0_r + 11'sd1;
    end else begin
      rm  = p_r[46:23];
      rg  = p_r[22];
      rs  = |p_r[21:0];
      rep = ep0_r;
    end
    rinc = rg & (rs | rm[0]);
    rsum = {1'b0, rm} + {24'd0, rinc};
  end

  // Round to integer, half to even, and saturate
  always_comb begin
    ish  = 5'(11'sd23 - ep_r);
    iw   = {m_r, 24'd0} >> ish;
    ih   = iw[23];
    ist  = |iw[22:0];
    iinc = ih & (ist | iw[24]);
    r9   = {1'b0, iw[31:24]} + {8'd0, iinc};
    qsat = sg3_r ? 8'sh80 : 8'sd127;
    if (xc3_r == XC_ZERO) q = 8'sd0;
    else if (xc3_r == XC_SAT || ep_r >= 11'sd7) q = qsat;
    else if (ep_r < -11'sd1) q = 8'sd0;
    else if (!sg3_r) q = (r9 > 9'd127) ? 8'sd127 : $signed(r9[7:0]);
    else q = (r9 >= 9'd128) ? 8'sh80 : $signed(8'd0 - r9[7:0]);
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (ctl.nrm_en) begin
      sg1_r <= sx ^ recip[31];
      xc1_r <= xc_n;
      mx_r  <= mx_n;
      exn_r <= exn_n;
    end
    if (ctl.mul_en) begin
      sg2_r <= sg1_r;
      xc2_r <= xc1_r;
      p_r   <= {1'b1, recip[22:0]} * mx_r;
      ep0_r <= $signed({exn_r[9], exn_r}) + $signed({3'b000, recip[30:23]}) - 11'sd127;
    end
    if (ctl.rnd_en) begin
      sg3_r <= sg2_r;
      xc3_r <= xc2_r;
      m_r   <= rsum[24] ? 24'h80_0000 : rsum[23:0];
      ep_r  <= rep + (rsum[24] ? 11'sd1 : 11'sd0);
    end
  end

endmodule

// ===== tb/q8_block_quantizer_test.sv =====
`default_nettype none

module q8_block_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLK = q8bq_pkg::BLOCK_SIZE_DEF;
  localparam int unsigned NSUB = BLK / q8bq_pkg::SUB_BLOCK_SIZE;
  localparam int unsigned LIMIT = 1000000;

  typedef struct {
    logic [31:0] sample;
    bit          drain;
  } beat_t;

  typedef struct {
    logic [63:0]                     lo;
    logic [63:0]                     hi;
    logic [q8bq_pkg::SUM_W-1:0]      sum;
    logic [31:0]                     scale;
    logic [q8bq_pkg::SUB_IDX_W-1:0]  idx;
    logic                            last;
  } sub_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_sample;
  logic        out_strobe;
  logic [63:0] out_quants_low;
  logic [63:0] out_quants_high;
  logic signed [q8bq_pkg::SUM_W-1:0] out_sub_block_sum;
  logic [31:0] out_block_scale;
  logic [q8bq_pkg::SUB_IDX_W-1:0] out_sub_block_index;
  logic        out_last_of_block;

  q8_block_quantizer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_sample           (in_sample),
    .out_strobe          (out_strobe),
    .out_quants_low      (out_quants_low),
    .out_quants_high     (out_quants_high),
    .out_sub_block_sum   (out_sub_block_sum),
    .out_block_scale     (out_block_scale),
    .out_sub_block_index (out_sub_block_index),
    .out_last_of_block   (out_last_of_block)
  );

  beat_t       pending[$];
  sub_result_t expected_subs[$];
  int unsigned issued_cnt;
  int unsigned accepted_cnt;
  int unsigned gap_left;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          burst_mode;

  // Shadow state of the quantizer
  logic [31:0] buf_store[BLK];
  int unsigned buf_fill;
  logic [31:0] max_mag;
  logic [31:0] max_val;

  // Clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Widen single bits to a real value exactly
  function automatic real single_to_real(logic [31:0] b);
    logic [63:0] d;
    real v;
    if (b[30:23] == 8'hff) begin
      d = {b[31], 11'h7ff, (b[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0};
      return $bitstoreal(d);
    end
    if (b[30:23] == 8'h00) begin
      v = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -v : v;
    end
    d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0};
    return $bitstoreal(d);
  endfunction

  // Round a real value to single bits, nearest-even, with subnormals
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0]     d;
    logic            s;
    int              e;
    int              shift;
    longint unsigned sig;
    longint unsigned kept;
    longint unsigned rem;
    longint unsigned half;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7ff)
      return (d[51:0] != 0) ? 32'h7fc0_0000 : {s, 8'hff, 23'h0};
    if (d[62:52] == 11'h000)
      return {s, 31'h0};
    e = int'(d[62:52]) - 1023;
    if (e > 127)
      return {s, 8'hff, 23'h0};
    sig = {12'h001, d[51:0]};
    shift = (e >= -126) ? 29 : 29 + (-126 - e);
    if (shift > 60)
      return {s, 31'h0};
    kept = sig >> shift;
    rem = sig & ((64'd1 << shift) - 1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && kept[0]))
      kept = kept + 1;
    if (e < -126)
      return {s, kept[30:0]};
    if (kept == (64'd1 << 24)) begin
      kept = kept >> 1;
      e = e + 1;
      if (e > 127)
        return {s, 8'hff, 23'h0};
    end
    return {s, 8'(e + 127), kept[22:0]};
  endfunction

  // Saturating nearest-even conversion of one product to int8
  function automatic int quant_of(logic [31:0] pb);
    real         pr;
    logic [31:0] sh;
    if (pb[30:23] == 8'hff && pb[22:0] != 0)
      return 0;
    pr = single_to_real(pb);
    if (pr > 127.0)
      return 127;
    if (pr < -128.0)
      return -128;
    sh = real_to_single(pr + 12582912.0);
    return int'(sh[22:0]) - 32'h0040_0000;
  endfunction

  // Take one sample; at a full block queue the sixteen sub-block results
  task automatic absorb_sample(logic [31:0] s);
    logic [31:0] mag;
    logic [31:0] recip;
    logic [31:0] scale;
    bit          zero_blk;
    sub_result_t r;
    int          q;
    int          total;
    mag = {1'b0, s[30:0]};
    if (buf_fill < BLK)
      buf_store[buf_fill] = s;
    // Only a strictly larger magnitude replaces; NaN never wins
    if (mag <= 32'h7f80_0000 && mag > max_mag) begin
      max_mag = mag;
      max_val = s;
    end
    buf_fill++;
    if (buf_fill < BLK)
      return;
    zero_blk = (max_mag == 32'h0);
    recip = 32'h0;
    scale = 32'h0;
    if (!zero_blk) begin
      recip = real_to_single(-128.0 / single_to_real(max_val));
      if (recip[30:0] == 31'h0)
        scale = {recip[31], 8'hff, 23'h0};
      else
        scale = real_to_single(1.0 / single_to_real(recip));
    end
    for (int sb = 0; sb < NSUB; sb++) begin
      r.lo = '0;
      r.hi = '0;
      total = 0;
      for (int k = 0; k < 16; k++) begin
        q = 0;
        if (!zero_blk)
          q = quant_of(real_to_single(single_to_real(recip) *
                                      single_to_real(buf_store[sb * 16 + k])));
        total += q;
        if (k < 8)
          r.lo[8*k +: 8] = q[7:0];
        else
          r.hi[8*(k-8) +: 8] = q[7:0];
      end
      r.sum = total[q8bq_pkg::SUM_W-1:0];
      r.scale = scale;
      r.idx = sb[q8bq_pkg::SUB_IDX_W-1:0];
      r.last = (sb + 1 == NSUB);
      expected_subs.push_back(r);
    end
    buf_fill = 0;
    max_mag = 32'h0;
    max_val = 32'h0;
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_cnt, field, got, want);
    err_cnt++;
  endtask

  // Check result beats, then take in accepted sample beats
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (expected_subs.size() == 0) begin
        report("unexpected beat", out_quants_low, 64'h0);
      end else begin
        sub_result_t w;
        w = expected_subs.pop_front();
        if (out_quants_low !== w.lo) report("quants_low", out_quants_low, w.lo);
        if (out_quants_high !== w.hi) report("quants_high", out_quants_high, w.hi);
        if (out_sub_block_sum !== w.sum) report("sub_block_sum", out_sub_block_sum, w.sum);
        if (out_block_scale !== w.scale) report("block_scale", out_block_scale, w.scale);
        if (out_sub_block_index !== w.idx)
          report("sub_block_index", out_sub_block_index, w.idx);
        if (out_last_of_block !== w.last)
          report("last_of_block", out_last_of_block, w.last);
      end
    end
    if (rst_n && start && !busy) begin
      absorb_sample(in_sample);
      accepted_cnt++;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode)
      return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(0, 2);
    if (r < 15) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Sample driver: hold a beat until taken, then idle for the chosen gap
  always @(negedge clk) begin
    beat_t b;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted_cnt != issued_cnt) begin
      // hold
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending.size() > 0 &&
                 !(pending[0].drain && (expected_subs.size() > 0 || busy))) begin
      b = pending.pop_front();
      in_sample <= b.sample;
      start <= 1'b1;
      issued_cnt++;
      if (issued_cnt % 64 == 0)
        burst_mode = ($urandom_range(0, 3) == 0);
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_sample(logic [31:0] s, bit drain = 1'b0);
    beat_t b;
    b.sample = s;
    b.drain = drain;
    pending.push_back(b);
  endtask

  function automatic logic [31:0] rand_near(int spread, int centre);
    int e;
    e = centre + $urandom_range(0, 2 * spread) - spread;
    if (e < 1) e = 1;
    if (e > 254) e = 254;
    return {1'($urandom_range(0, 1)), 8'(e), 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_odd();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fc0_0001;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      default: return 32'h807f_ffff;
    endcase
  endfunction

  // Fill one super-block; mode picks the sample mix
  task automatic fill_block(int mode, int done_already);
    logic [31:0] s;
    int centre;
    centre = $urandom_range(60, 190);
    for (int i = done_already; i < BLK; i++) begin
      case (mode)
        0: s = $urandom;
        1: s = ($urandom_range(0, 31) == 0) ? rand_odd() : rand_near(8, centre);
        2: s = ($urandom_range(0, 1) == 0) ? {1'($urandom_range(0, 1)), 31'h0}
                                          : {1'($urandom_range(0, 1)), 8'hff,
                                             23'($urandom) | 23'h1};
        default: s = {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
      endcase
      push_sample(s, i == done_already && $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    logic [31:0] dir[$];
    rst_n = 1'b0;
    start = 1'b0;
    in_sample = 32'h0;
    issued_cnt = 0;
    accepted_cnt = 0;
    gap_left = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    burst_mode = 1'b0;
    buf_fill = 0;
    max_mag = 32'h0;
    max_val = 32'h0;
    for (int i = 0; i < BLK; i++) buf_store[i] = 32'h0;

    // Directed samples open the first block: -128 ahead of +128 (first of equals wins), ties,
    // saturation, NaN and signed zeros; the random rest of the block may set a larger maximum
    dir = '{32'hc300_0000, 32'h4300_0000, 32'h3f00_0000, 32'h3fc0_0000,
            32'h4020_0000, 32'hbf00_0000, 32'hbfc0_0000, 32'h42ff_0000,
            32'hc2ff_0000, 32'h42fe_0000, 32'hc300_0000, 32'h7fc0_0000,
            32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000,
            32'h0000_0001, 32'h807f_ffff, 32'h3f80_0000, 32'h3e80_0000,
            32'h4101_0000, 32'hc101_0000, 32'h3fff_ffff};
    foreach (dir[i]) push_sample(dir[i]);
    fill_block(1, dir.size());
    // Pause until all results have drained, then one block of a special kind
    case ($urandom_range(0, 5))
      0: begin
        // Positive infinite largest
        push_sample(32'h7f80_0000, 1'b1);
        fill_block(1, 1);
      end
      1: begin
        // Negative infinite largest
        push_sample(32'hff80_0000, 1'b1);
        fill_block(0, 1);
      end
      2: begin
        // All-zero and NaN block
        push_sample(32'h8000_0000, 1'b1);
        fill_block(2, 1);
      end
      3: begin
        // Subnormal largest: recip overflows
        push_sample(32'h0000_0001, 1'b1);
        fill_block(3, 1);
      end
      4: begin
        // Largest finite value dominates
        push_sample(32'h7f7f_ffff, 1'b1);
        fill_block(1, 1);
      end
      default: begin
        push_sample(rand_near(8, 127), 1'b1);
        fill_block(1, 1);
      end
    endcase

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending.size() == 0 && accepted_cnt == issued_cnt);
    wait (expected_subs.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== q8_block_quantizer.f =====
rtl/q8bq_pkg.sv
rtl/q8bq_recip.sv
rtl/q8bq_quant.sv
rtl/q8_block_quantizer.sv
tb/q8_block_quantizer_test.sv
